@@ src/escape_string_to_hex_text_macros.svh @@
// Assertion macros for the escape string to hex text block.
// Used by the decode and emit stages; needs clk and rst in scope.
`ifndef ESCAPE_STRING_TO_HEX_TEXT_MACROS_SVH
`define ESCAPE_STRING_TO_HEX_TEXT_MACROS_SVH

// Check a same-cycle implication outside reset.
`define ESHX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle, outside reset.
`define ESHX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/eshx_pkg.sv @@
// Shared types, constants and helper functions for the escape string to hex text block.
// No dependencies.
`default_nettype none

package eshx_pkg;

  localparam int JOB_CHARS = 8;
  localparam int IDX_W     = $clog2(JOB_CHARS);
  localparam int CNT_W     = $clog2(JOB_CHARS + 1);

  localparam logic [7:0] BACKSLASH = 8'h5c;
  localparam logic [7:0] LETTER_X  = 8'h78;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  localparam logic [7:0] NIBBLE_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_HEX0,
    MODE_HEX1
  } esc_mode_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       char_is_final;
  } char_item_t;

  typedef struct packed {
    logic [7:0] hex_char;
    logic       run_last;
    logic       string_done;
  } hex_item_t;

  // Characters produced by one input transaction, first character in slot 0
  typedef struct packed {
    logic [JOB_CHARS-1:0][7:0] chars;
    logic [CNT_W-1:0]          count;
    logic                      fin;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_digit_t;

  typedef struct packed {
    logic       known;
    logic [7:0] value;
  } named_esc_t;

  // Map an ASCII hex digit, either case, to its value
  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t r;
    r.ok  = 1'b1;
    r.nib = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.nib = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Look up the byte of a named escape
  function automatic named_esc_t named_escape(input logic [7:0] c);
    named_esc_t r;
    r.known = 1'b1;
    unique case (c)
      8'h5c:   r.value = 8'h5c;
      8'h6e:   r.value = 8'h0a;
      8'h74:   r.value = 8'h09;
      8'h61:   r.value = 8'h07;
      8'h62:   r.value = 8'h08;
      8'h66:   r.value = 8'h0c;
      8'h72:   r.value = 8'h0d;
      8'h76:   r.value = 8'h0b;
      8'h27:   r.value = 8'h27;
      8'h22:   r.value = 8'h22;
      8'h30:   r.value = 8'h00;
      8'h3f:   r.value = 8'h3f;
      default: begin
        r.known = 1'b0;
        r.value = c;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/eshx_decode.sv @@
// Escape decoder: holds the escape state and turns one input character into a job
// of output characters. Depends on eshx_pkg and the assertion macro header.
`default_nettype none
`include "escape_string_to_hex_text_macros.svh"

module eshx_decode
  import eshx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire char_item_t item,
  input  wire logic       take,
  output job_t            job
);

  esc_mode_t  mode, mode_next;
  logic [7:0] held_digit, held_digit_next;
  logic       prefix_sent, prefix_sent_next;

  logic [7:0] c;
  logic       fin;
  hex_digit_t c_hex, held_hex;
  named_esc_t named;

  logic [7:0]       bytes [4];
  logic [2:0]       nbytes;
  logic [7:0]       hx    [8];
  logic [7:0]       seq   [10];
  logic [CNT_W:0]   total;

  assign c        = item.char_in;
  assign fin      = item.char_is_final;
  assign c_hex    = hex_value(c);
  assign held_hex = hex_value(held_digit);
  assign named    = named_escape(c);

  // Next escape state
  always_comb begin
    mode_next        = MODE_NORMAL;
    held_digit_next  = held_digit;
    prefix_sent_next = !fin;
    unique case (mode)
      MODE_NORMAL: begin
        if (c == BACKSLASH && !fin) mode_next = MODE_ESC;
      end
      MODE_ESC: begin
        if (c == LETTER_X && !fin) mode_next = MODE_HEX0;
      end
      MODE_HEX0: begin
        if (!fin && c_hex.ok) begin
          held_digit_next = c;
          mode_next       = MODE_HEX1;
        end else if (c == BACKSLASH && !fin) begin
          mode_next = MODE_ESC;
        end
      end
      MODE_HEX1: begin
        if (!(held_hex.ok && c_hex.ok) && c == BACKSLASH && !fin) mode_next = MODE_ESC;
      end
      default: mode_next = MODE_NORMAL;
    endcase
  end

  // Decoded bytes of this character
  always_comb begin
    bytes[0] = c;
    bytes[1] = c;
    bytes[2] = c;
    bytes[3] = c;
    nbytes   = 3'd0;
    unique case (mode)
      MODE_NORMAL: begin
        if (!(c == BACKSLASH && !fin)) nbytes = 3'd1;
      end
      MODE_ESC: begin
        if (c == LETTER_X) begin
          if (fin) begin
            bytes[0] = BACKSLASH;
            bytes[1] = LETTER_X;
            nbytes   = 3'd2;
          end
        end else if (named.known) begin
          bytes[0] = named.value;
          nbytes   = 3'd1;
        end else begin
          bytes[0] = BACKSLASH;
          nbytes   = 3'd2;
        end
      end
      MODE_HEX0: begin
        if (fin || !c_hex.ok) begin
          bytes[0] = BACKSLASH;
          bytes[1] = LETTER_X;
          nbytes   = (c == BACKSLASH && !fin) ? 3'd2 : 3'd3;
        end
      end
      MODE_HEX1: begin
        if (held_hex.ok && c_hex.ok) begin
          bytes[0] = {held_hex.nib, c_hex.nib};
          nbytes   = 3'd1;
        end else begin
          bytes[0] = BACKSLASH;
          bytes[1] = LETTER_X;
          bytes[2] = held_digit;
          nbytes   = (c == BACKSLASH && !fin) ? 3'd3 : 3'd4;
        end
      end
      default: nbytes = 3'd0;
    endcase
  end

  // Expand bytes to hex text, prefix first, and cap at the job size
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hx[2*k]   = NIBBLE_CHARS[bytes[k][7:4]];
      hx[2*k+1] = NIBBLE_CHARS[bytes[k][3:0]];
    end
    if (!prefix_sent) begin
      seq[0] = CHAR_ZERO;
      seq[1] = LETTER_X;
      for (int k = 0; k < 8; k++) seq[k+2] = hx[k];
    end else begin
      for (int k = 0; k < 8; k++) seq[k] = hx[k];
      seq[8] = CHAR_ZERO;
      seq[9] = CHAR_ZERO;
    end
    for (int k = 0; k < JOB_CHARS; k++) job.chars[k] = seq[k];
    total = (CNT_W + 1)'({!prefix_sent, 1'b0}) + (CNT_W + 1)'({nbytes, 1'b0});
    job.count = (total > (CNT_W + 1)'(JOB_CHARS)) ? CNT_W'(JOB_CHARS) : total[CNT_W-1:0];
    job.fin   = fin;
  end

  // Advance the escape state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NORMAL;
      prefix_sent <= 1'b0;
    end else if (take) begin
      mode        <= mode_next;
      prefix_sent <= prefix_sent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) held_digit <= held_digit_next;
  end

  `ESHX_ASSERT_NOW(a_pending_has_prefix, mode != MODE_NORMAL, prefix_sent, "escape pending before prefix")
  `ESHX_ASSERT_NOW(a_final_has_output, take && fin, job.count != '0, "final character produced no output")
  `ESHX_ASSERT_NOW(a_held_digit_is_hex, mode == MODE_HEX1, held_hex.ok, "held digit is not hex")

endmodule

`default_nettype wire

@@ src/eshx_emit.sv @@
// Emitter: holds one decoded job and sends its characters one per cycle while
// not stalled, through the result register. Needs eshx_pkg, assertion macros.
`default_nettype none
`include "escape_string_to_hex_text_macros.svh"

module eshx_emit
  import eshx_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire job_t  job,
  input  wire logic  load,
  output logic       free,
  output logic       hex_valid,
  input  wire logic  hex_ready,
  output hex_item_t  hex_data
);

  job_t             cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;
  logic             emit;
  logic             last;

  assign emit = cur_valid && (!hex_valid || hex_ready);
  assign last = ({1'b0, idx} == cur.count - CNT_W'(1));
  assign free = !cur_valid || (emit && last);

  // Hold the current job and step through its characters
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= (job.count != '0);
      idx       <= '0;
    end else if (emit) begin
      if (last) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur <= job;
  end

  // Drive the result register; drop valid once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      hex_valid <= 1'b0;
    end else if (emit) begin
      hex_valid <= 1'b1;
    end else if (hex_ready) begin
      hex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hex_data.hex_char    <= cur.chars[idx];
      hex_data.run_last    <= last;
      hex_data.string_done <= last && cur.fin;
    end
  end

  `ESHX_ASSERT_NOW(a_load_when_free, load, free, "job loaded over a busy slot")
  `ESHX_ASSERT_NOW(a_idx_in_range, cur_valid, {1'b0, idx} < cur.count, "character index past job end")
  `ESHX_ASSERT_NEXT(a_slot_clears, emit && last && !load, !cur_valid, "slot busy after last character")

endmodule

`default_nettype wire

@@ src/escape_string_to_hex_text.sv @@
// Top level of the escape string to hex text block: decode stage and emitter.
// Depends on eshx_pkg, eshx_decode and eshx_emit.
//
//   channel | valid      | ready      | payload
//   --------+------------+------------+--------------------------------------
//   char    | char_valid | char_ready | char_data (char_in, char_is_final)
//   hex     | hex_valid  | hex_ready  | hex_data (hex_char, run_last, string_done)
//
// Each character is decoded in the cycle it is accepted; its zero to eight output
// characters then leave one per cycle from the result register while hex_ready holds:
// a plain character gives two, the first of a string four, a failed hex escape
// up to eight. A new character is accepted in the cycle the previous one's last output
// is loaded into the result register. Reset clears escape state and empties both stages.
// A stall on hex_ready holds the result and backs up to char_ready.
`default_nettype none

module escape_string_to_hex_text
  import eshx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       char_valid,
  output logic            char_ready,
  input  wire char_item_t char_data,
  output logic            hex_valid,
  input  wire logic       hex_ready,
  output hex_item_t       hex_data
);

  job_t job;
  logic take;
  logic free;

  assign char_ready = free;
  assign take       = char_valid && free;

  // Decode the accepted character into a job
  eshx_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .item (char_data),
    .take (take),
    .job  (job)
  );

  // Send the job's characters out
  eshx_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .load      (take),
    .free      (free),
    .hex_valid (hex_valid),
    .hex_ready (hex_ready),
    .hex_data  (hex_data)
  );

endmodule

`default_nettype wire
